// ----- src/multi_axis_quadrature_pid_servo_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the servo RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_AXIS_QUADRATURE_PID_SERVO_UNIT_MACROS_SVH
`define MULTI_AXIS_QUADRATURE_PID_SERVO_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/mqps_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo package
// Types, codes and constants shared by the servo modules.
// ----------------------------------------------------------------------------
package mqps_pkg;
    localparam int AXES_DEF = 6;
    localparam int FRAC_DEF = 8;
    localparam int PIN_BITS = 6;
    localparam int CNT_W = 32;
    localparam int REF_W = 40;
    localparam int SUM_W = 48;
    localparam int GAIN_W = 16;
    localparam int POS_W = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W = 72;

    localparam logic [1:0] ACT_PINS = 2'd0;
    localparam logic [1:0] ACT_REF = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] REG_KP = 3'd0;
    localparam logic [2:0] REG_KI = 3'd1;
    localparam logic [2:0] REG_KD = 3'd2;
    localparam logic [2:0] REG_SAT = 3'd3;
    localparam logic [2:0] REG_DZ = 3'd4;
    localparam logic [2:0] REG_CPR = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REF_MUL,
        ST_REF_DIV,
        ST_REF_WR,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_OUT,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic load;
        logic ref_mul;
        logic div_step;
        logic ref_wr;
        logic err;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic emit;
        logic next_axis;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_axis;
        logic out_busy;
    } sts_t;
endpackage

// ----- src/mqps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Servo controller
// Sequences set-reference division and per-axis PID evaluation.
// ----------------------------------------------------------------------------
`include "multi_axis_quadrature_pid_servo_unit_macros.svh"
module mqps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_action,
    output logic           in_stall,
    input  mqps_pkg::sts_t sts,
    output mqps_pkg::cmd_t cmd
);
    import mqps_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_action == ACT_REF)
                    begin
                        state_next = ST_REF_MUL;
                    end
                    else if (in_action == ACT_TICK)
                    begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_REF_MUL:
            begin
                cmd.ref_mul = 1'b1;
                state_next = ST_REF_DIV;
            end
            ST_REF_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_REF_WR;
                end
            end
            ST_REF_WR:
            begin
                cmd.ref_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ERR:
            begin
                cmd.err = 1'b1;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_p = 1'b1;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_i = 1'b1;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_d = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit = 1'b1;
                    cmd.next_axis = 1'b1;
                    state_next = sts.last_axis ? ST_WAIT : ST_ERR;
                end
            end
            ST_WAIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NXT(a_err_to_mul, clk, rst_n, state_reg == ST_ERR, state_reg == ST_MUL_P)
    `ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !sts.out_busy)
endmodule

// ----- src/mqps_datapath.sv -----
// ----------------------------------------------------------------------------
// Servo datapath
// Encoder counters, reference divider, shared PID multiplier, output stage.
// ----------------------------------------------------------------------------
`include "multi_axis_quadrature_pid_servo_unit_macros.svh"
module mqps_datapath #(
    parameter int AXES = mqps_pkg::AXES_DEF,
    parameter int FRACTION_BITS = mqps_pkg::FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mqps_pkg::cmd_t                        cmd,
    output mqps_pkg::sts_t                        sts,
    input  logic [1:0]                            action,
    input  logic [mqps_pkg::PIN_BITS-1:0]         pins_a,
    input  logic [mqps_pkg::PIN_BITS-1:0]         pins_b,
    input  logic [2:0]                            motor,
    input  logic signed [mqps_pkg::POS_W-1:0]     position_deg,
    input  logic                                  cfg_valid,
    input  logic [mqps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mqps_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [2:0]                            axis,
    output logic                                  forward,
    output logic [7:0]                            duty,
    output logic signed [mqps_pkg::CNT_W-1:0]     position_count,
    output logic                                  last
);
    import mqps_pkg::*;

    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int AXC_W = $clog2(AXES + 1);
    localparam int PROD_W = POS_W + 17 + FRACTION_BITS;
    localparam int QW = PROD_W;
    localparam int QB = ((QW + 7) / 8) * 8;
    localparam int DIG = QB / 8;
    localparam int QC_W = $clog2(DIG);
    localparam int SH = 8 + FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] ERR_MAX = (ACC_W)'(( 64'sd1 <<< (REF_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ERR_MIN = -ERR_MAX - 1;
    localparam logic signed [ACC_W-1:0] SUM_MAX = (ACC_W)'(( 64'sd1 <<< (SUM_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SUM_MIN = -SUM_MAX - 1;
    localparam logic [8:0] DIV_C = 9'd360;
    // ceil(2^27 / 360), exact for every digit step operand below 360 * 256
    localparam logic [18:0] RECIP = 19'd372828;

    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [7:0] sat_reg, dz_reg;
    logic [15:0] cpr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
            sat_reg <= 8'd255;
            dz_reg <= '0;
            cpr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KP: kp_reg <= cfg_data;
                REG_KI: ki_reg <= cfg_data;
                REG_KD: kd_reg <= cfg_data;
                REG_SAT: sat_reg <= cfg_data[7:0];
                REG_DZ: dz_reg <= cfg_data[7:0];
                REG_CPR: cpr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // quadrature decode, one sample per accepted pin item
    logic [CNT_W-1:0] cnt_reg [AXES];
    logic [PIN_BITS-1:0] pa_reg, pb_reg;
    logic pins_go;
    assign pins_go = cmd.load && (action == ACT_PINS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg <= '0;
            pb_reg <= '0;
        end
        else if (pins_go)
        begin
            pa_reg <= pins_a;
            pb_reg <= pins_b;
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_enc
        if (g < PIN_BITS)
        begin : g_pin
            logic ea, eb, eq;
            logic [CNT_W-1:0] d1, d2;
            assign ea = pins_a[g] ^ pa_reg[g];
            assign eb = pins_b[g] ^ pb_reg[g];
            assign eq = pins_a[g] == pins_b[g];
            assign d1 = ea ? (eq ? CNT_W'(1) : '1) : '0;
            assign d2 = eb ? (eq ? '1 : CNT_W'(1)) : '0;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg[g] <= '0;
                end
                else if (pins_go)
                begin
                    cnt_reg[g] <= cnt_reg[g] + d1 + d2;
                end
            end
        end
        else
        begin : g_nopin
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg[g] <= '0;
                end
            end
        end
    end

    // reference: magnitude product, divide by 360 one byte a cycle,
    // each quotient byte by reciprocal multiply
    logic [2:0] mot_reg;
    logic neg_reg;
    logic [POS_W-1:0] pmag_reg;
    logic [QB-1:0] quo_reg;
    logic [8:0] rem_reg;
    logic [QC_W-1:0] qcnt_reg;
    logic signed [REF_W-1:0] ref_reg [AXES];

    logic [QB-1:0] prod_mag;
    logic [16:0] dig_x;
    logic [35:0] dig_p;
    logic [7:0] dig_q;
    logic [16:0] dig_r;
    logic signed [QB:0] qs;
    assign prod_mag = (QB'(pmag_reg) * QB'(cpr_reg)) << FRACTION_BITS;
    assign dig_x = {rem_reg, quo_reg[QB-1 -: 8]};
    assign dig_p = 36'(dig_x) * 36'(RECIP);
    assign dig_q = dig_p[34:27];
    assign dig_r = dig_x - 17'(dig_q) * 17'(DIV_C);
    assign qs = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign sts.div_done = (qcnt_reg == QC_W'(DIG - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mot_reg <= motor;
            neg_reg <= position_deg[POS_W-1];
            pmag_reg <= position_deg[POS_W-1] ? POS_W'(-position_deg) : POS_W'(position_deg);
        end
        if (cmd.ref_mul)
        begin
            quo_reg <= prod_mag;
            rem_reg <= '0;
            qcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            qcnt_reg <= qcnt_reg + 1'b1;
            rem_reg <= dig_r[8:0];
            quo_reg <= {quo_reg[QB-9:0], dig_q};
        end
    end

    // PID per axis, one shared multiplier
    logic [AX_W-1:0] ax_reg;
    logic signed [ACC_W-1:0] e_reg, acc_reg, prod_reg;
    logic signed [SUM_W-1:0] sum_reg [AXES];
    logic signed [REF_W-1:0] perr_reg [AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                ref_reg[k] <= '0;
                sum_reg[k] <= '0;
                perr_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.ref_wr && ({1'b0, mot_reg} < (AXC_W > 3 ? AXC_W : 4)'(AXES)))
            begin
                ref_reg[AX_W'(mot_reg)] <= qs[REF_W-1:0];
            end
            if (cmd.mul_d)
            begin
                perr_reg[ax_reg] <= e_reg[REF_W-1:0];
                if (ACC_W'(sum_reg[ax_reg]) + e_reg > SUM_MAX)
                begin
                    sum_reg[ax_reg] <= SUM_MAX[SUM_W-1:0];
                end
                else if (ACC_W'(sum_reg[ax_reg]) + e_reg < SUM_MIN)
                begin
                    sum_reg[ax_reg] <= SUM_MIN[SUM_W-1:0];
                end
                else
                begin
                    sum_reg[ax_reg] <= SUM_W'(ACC_W'(sum_reg[ax_reg]) + e_reg);
                end
            end
        end
    end

    logic signed [ACC_W-1:0] e_raw;
    logic signed [GAIN_W-1:0] mg;
    logic signed [ACC_W-1:0] mv;
    assign e_raw = ACC_W'(ref_reg[ax_reg]) - (ACC_W'($signed(cnt_reg[ax_reg])) <<< FRACTION_BITS);

    always_comb
    begin
        mg = kp_reg;
        mv = e_reg;
        if (cmd.mul_i)
        begin
            mg = ki_reg;
            mv = ACC_W'(sum_reg[ax_reg]);
        end
        else if (cmd.mul_d)
        begin
            mg = kd_reg;
            mv = e_reg - ACC_W'(perr_reg[ax_reg]);
        end
    end

    // drive: truncate toward zero, clamp, dead zone
    logic signed [ACC_W-1:0] acc_tot, drv, sat_s;
    logic [ACC_W-1:0] mag;
    assign acc_tot = acc_reg + prod_reg;
    assign drv = (acc_tot < 0) ? -((-acc_tot) >>> SH) : (acc_tot >>> SH);
    assign sat_s = ACC_W'({1'b0, sat_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
        end
        else if (cmd.next_axis)
        begin
            ax_reg <= (ax_reg == AX_W'(AXES - 1)) ? '0 : ax_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.err)
        begin
            e_reg <= (e_raw > ERR_MAX) ? ERR_MAX : ((e_raw < ERR_MIN) ? ERR_MIN : e_raw);
            acc_reg <= '0;
            prod_reg <= '0;
        end
        if (cmd.mul_p || cmd.mul_i || cmd.mul_d)
        begin
            acc_reg <= acc_reg + prod_reg;
            prod_reg <= ACC_W'(mg) * mv;
        end
    end

    logic signed [ACC_W-1:0] dcl;
    assign dcl = (drv > sat_s) ? sat_s : ((drv < -sat_s) ? -sat_s : drv);
    assign mag = (dcl < 0) ? ACC_W'(-dcl) : ACC_W'(dcl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            axis <= 3'(ax_reg);
            position_count <= cnt_reg[ax_reg];
            last <= (ax_reg == AX_W'(AXES - 1));
            if (mag < ACC_W'(dz_reg))
            begin
                forward <= 1'b0;
                duty <= '0;
            end
            else
            begin
                forward <= dcl > 0;
                duty <= mag[7:0];
            end
        end
    end

    assign sts.out_busy = out_valid && out_stall;
    assign sts.last_axis = (ax_reg == AX_W'(AXES - 1));

    `ASSERT_NXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid)
    `ASSERT_IMP(a_axis_range, clk, rst_n, out_valid, {1'b0, axis} < 4'(AXES))
    `ASSERT_IMP(a_duty_sat, clk, rst_n, out_valid, duty <= sat_reg)
endmodule

// ----- src/multi_axis_quadrature_pid_servo_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-axis quadrature PID servo
// Six-axis x4 quadrature counter with one PID position loop per axis.
// ----------------------------------------------------------------------------
// Pin-sample items may follow each other every clock. A set-reference item
// stalls the input through a product step, six byte steps of the divide by
// 360 (each a reciprocal multiply) and a write step. A tick runs each axis
// through error, three products and output on the single shared multiplier,
// stalls the input further while the result side stalls, and emits AXES
// results, axis 0 first, with last on the final one.
module multi_axis_quadrature_pid_servo_unit #(
    parameter int AXES = mqps_pkg::AXES_DEF,
    parameter int FRACTION_BITS = mqps_pkg::FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            action,
    input  logic [mqps_pkg::PIN_BITS-1:0]         pins_a,
    input  logic [mqps_pkg::PIN_BITS-1:0]         pins_b,
    input  logic [2:0]                            motor,
    input  logic signed [mqps_pkg::POS_W-1:0]     position_deg,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mqps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mqps_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [2:0]                            axis,
    output logic                                  forward,
    output logic [7:0]                            duty,
    output logic signed [mqps_pkg::CNT_W-1:0]     position_count,
    output logic                                  last
);
    import mqps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    mqps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (action),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mqps_datapath #(
        .AXES          (AXES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .action         (action),
        .pins_a         (pins_a),
        .pins_b         (pins_b),
        .motor          (motor),
        .position_deg   (position_deg),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .axis           (axis),
        .forward        (forward),
        .duty           (duty),
        .position_count (position_count),
        .last           (last)
    );
endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Servo unit testbench
// Drives pin samples, reference moves and control ticks into the six-axis
// servo, predicts every drive result and checks each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import mqps_pkg::*;

    localparam int NUM_AXES = 6;
    localparam int FRAC = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 80;
    localparam longint ERR_HI = 64'sd549755813887;
    localparam longint ERR_LO = -64'sd549755813888;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355328;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [2:0]  axis;
        logic        forward;
        logic [7:0]  duty;
        logic [31:0] count;
        logic        last;
    } drive_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] action;
    logic [5:0] pins_a;
    logic [5:0] pins_b;
    logic [2:0] motor;
    logic signed [20:0] position_deg;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic out_valid;
    logic out_stall;
    logic [2:0] axis;
    logic forward;
    logic [7:0] duty;
    logic signed [31:0] position_count;
    logic last;

    // predictor state
    longint kp, ki, kd;
    int unsigned sat, dz, cpr;
    logic [31:0] enc_count [NUM_AXES];
    logic [5:0] last_a, last_b;
    longint target [NUM_AXES];
    longint integ [NUM_AXES];
    longint last_err [NUM_AXES];

    drive_t drive_queue [$];
    int mismatches;
    int drives_seen;
    int ticks_sent;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    multi_axis_quadrature_pid_servo_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .pins_a(pins_a), .pins_b(pins_b),
        .motor(motor), .position_deg(position_deg),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .axis(axis), .forward(forward), .duty(duty),
        .position_count(position_count), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void predict_register(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_KP:  kp = longint'(signed'(val));
            REG_KI:  ki = longint'(signed'(val));
            REG_KD:  kd = longint'(signed'(val));
            REG_SAT: sat = {24'd0, val[7:0]};
            REG_DZ:  dz = {24'd0, val[7:0]};
            REG_CPR: cpr = {16'd0, val};
            default: ;
        endcase
    endfunction

    function automatic void predict_item(logic [1:0] act, logic [5:0] a, logic [5:0] b,
                                         logic [2:0] m, logic signed [20:0] deg);
        longint pos, err, acc, drv, mag, prod;
        logic [63:0] wrapped;
        drive_t d;
        if (act == ACT_PINS)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (a[i] != last_a[i])
                    enc_count[i] += (a[i] == b[i]) ? 32'd1 : 32'hFFFF_FFFF;
                if (b[i] != last_b[i])
                    enc_count[i] += (a[i] != b[i]) ? 32'd1 : 32'hFFFF_FFFF;
            end
            last_a = a;
            last_b = b;
        end
        else if (act == ACT_REF)
        begin
            if (m < NUM_AXES)
            begin
                prod = longint'(deg) * longint'(cpr) * (64'sd1 <<< FRAC) / 360;
                wrapped = prod;
                target[m] = longint'(signed'(wrapped[39:0]));
            end
        end
        else if (act == ACT_TICK)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos = longint'(signed'(enc_count[i]));
                err = clip(target[i] - pos * (64'sd1 <<< FRAC), ERR_LO, ERR_HI);
                acc = kp * err + ki * integ[i] + kd * (err - last_err[i]);
                drv = clip(acc / (64'sd1 <<< (8 + FRAC)), -longint'(sat), longint'(sat));
                mag = drv < 0 ? -drv : drv;
                if (mag < longint'(dz))
                begin
                    drv = 0;
                    mag = 0;
                end
                d.axis = 3'(i);
                d.forward = drv > 0;
                d.duty = mag[7:0];
                d.count = enc_count[i];
                d.last = (i == NUM_AXES - 1);
                drive_queue.push_back(d);
                integ[i] = clip(integ[i] + err, SUM_LO, SUM_HI);
                last_err[i] = err;
            end
        end
    endfunction

    // transfer one input item; valid stays up until the next item or a drain
    task automatic send_item(logic [1:0] act, logic [5:0] a, logic [5:0] b,
                             logic [2:0] m, logic signed [20:0] deg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        pins_a <= a;
        pins_b <= b;
        motor <= m;
        position_deg <= deg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(act, a, b, m, deg);
        if (act == ACT_TICK)
            ticks_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        predict_register(idx, val);
    endtask

    task automatic load_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                              logic [7:0] s, logic [7:0] z, logic [15:0] c);
        drain();
        write_register(REG_KP, p);
        write_register(REG_KI, i);
        write_register(REG_KD, d);
        write_register(REG_SAT, {8'd0, s});
        write_register(REG_DZ, {8'd0, z});
        write_register(REG_CPR, c);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int snd, int rcv);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
    endtask

    // walk all axes through well-formed quadrature steps
    task automatic step_encoder(int steps);
        logic [5:0] a, b, dir;
        dir = 6'($urandom);
        a = last_a;
        b = last_b;
        for (int k = 0; k < steps; k++)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                if (dir[i] ^ (a[i] == b[i]))
                    b[i] = ~b[i];
                else
                    a[i] = ~a[i];
            send_item(ACT_PINS, a, b, 3'd0, '0);
        end
    endtask

    task automatic test_directed();
        load_gains(16'h0100, 16'h0000, 16'h0000, 8'd255, 8'd0, 16'd4096);
        send_item(ACT_TICK, '0, '0, 3'd0, '0);
        send_item(ACT_PINS, 6'h3F, 6'h00, 3'd0, '0);
        send_item(ACT_PINS, 6'h3F, 6'h3F, 3'd0, '0);
        // both channels toggle together: nets zero
        send_item(ACT_PINS, 6'h00, 6'h00, 3'd0, '0);
        send_item(ACT_PINS, 6'h2A, 6'h15, 3'd0, '0);
        send_item(ACT_REF, '0, '0, 3'd0, 21'sd1);
        send_item(ACT_REF, '0, '0, 3'd1, -21'sd1);
        send_item(ACT_REF, '0, '0, 3'd2, 21'sd1048575);
        send_item(ACT_REF, '0, '0, 3'd5, 21'sh10_0000);
        send_item(ACT_REF, '0, '0, 3'd6, 21'sd90);
        send_item(ACT_REF, '0, '0, 3'd7, 21'sd90);
        send_item(ACT_SPARE, 6'h3F, 6'h3F, 3'd7, -21'sd1);
        send_item(ACT_TICK, '0, '0, 3'd0, '0);
        load_gains(16'h8000, 16'h7FFF, 16'h7FFF, 8'd0, 8'd255, 16'hFFFF);
        send_item(ACT_REF, '0, '0, 3'd3, 21'sd1048575);
        send_item(ACT_REF, '0, '0, 3'd4, 21'sh10_0000);
        send_item(ACT_TICK, '0, '0, 3'd0, '0);
        load_gains(16'h0040, 16'h0010, 16'hFFC0, 8'd100, 8'd20, 16'd0);
        send_item(ACT_REF, '0, '0, 3'd0, 21'sd500);
        send_item(ACT_TICK, '0, '0, 3'd0, '0);
        send_item(ACT_TICK, '0, '0, 3'd0, '0);
    endtask

    task automatic test_random(int items);
        int pick;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                step_encoder($urandom_range(1, 4));
            else if (pick < 55)
                send_item(ACT_PINS, 6'($urandom), 6'($urandom), 3'd0, '0);
            else if (pick < 70)
                send_item(ACT_REF, 6'($urandom), 6'($urandom), 3'($urandom_range(0, 7)),
                          ($urandom_range(3) == 0) ? 21'($urandom)
                                                   : 21'($signed($urandom_range(0, 1440)) - 720));
            else if (pick < 97)
                send_item(ACT_TICK, 6'($urandom), 6'($urandom), 3'($urandom), 21'($urandom));
            else
                send_item(ACT_SPARE, 6'($urandom), 6'($urandom), 3'($urandom), 21'($urandom));
        end
    endtask

    task automatic test_phases();
        set_idling(0, 0);
        test_random(15);
        load_gains(16'h0200, 16'h0004, 16'h0080, 8'd200, 8'd5, 16'd2048);
        set_idling(50, 0);
        test_random(15);
        set_idling(0, 50);
        test_random(15);
        // hold off until all drive results are in
        drain();
        load_gains(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom));
        set_idling(15, 15);
        test_random(15);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        drive_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            drives_seen++;
            if (drive_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive result axis %0d", axis);
            end
            else
            begin
                want = drive_queue.pop_front();
                if (want.axis !== axis || want.forward !== forward || want.duty !== duty
                    || want.count !== position_count || want.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"axis %0d: exp fwd %0d duty %0d cnt %0d last %0d, ",
                                  "got axis %0d fwd %0d duty %0d cnt %0d last %0d"},
                                 want.axis, want.forward, want.duty, $signed(want.count),
                                 want.last, axis, forward, duty, position_count, last);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("multi_axis_quadrature_pid_servo_unit test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        pins_a = '0;
        pins_b = '0;
        motor = '0;
        position_deg = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_stall = 1'b0;
        mismatches = 0;
        drives_seen = 0;
        ticks_sent = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        kp = 0;
        ki = 0;
        kd = 0;
        sat = 255;
        dz = 0;
        cpr = 0;
        last_a = '0;
        last_b = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            enc_count[i] = '0;
            target[i] = 0;
            integ[i] = 0;
            last_err[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_phases();
        drain();
        $display("covered %0d control ticks and %0d drive results over four idling phases",
                 ticks_sent, drives_seen);
        if (mismatches == 0 && drive_queue.size() == 0)
            $display("multi_axis_quadrature_pid_servo_unit test passed");
        else
            $display("multi_axis_quadrature_pid_servo_unit test failed");
        $finish;
    end
endmodule
